/* rtl/bdq_pkg.sv */
// Shared types and codes for the bounded deque with search.
package bdq_pkg;

    // Request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_REMOVE     = 3'd4;
    localparam logic [2:0] REQ_SEARCH     = 3'd5;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    // Logical index that drives the read port
    typedef enum logic [1:0] {
        RD_FRONT = 2'd0,
        RD_LAST  = 2'd1,
        RD_K1    = 2'd2,
        RD_K2    = 2'd3
    } t_rd_sel;

    // Slot that the write port targets
    typedef enum logic [1:0] {
        WR_HEAD_M = 2'd0,
        WR_TAIL   = 2'd1,
        WR_K      = 2'd2
    } t_wr_sel;

    typedef struct packed {
        logic       take;
        logic       rd_en;
        t_rd_sel    rd_sel;
        logic       wr_en;
        t_wr_sel    wr_sel;
        logic       wr_from_rd;
        logic       k_clr;
        logic       k_inc;
        logic       head_dec;
        logic       head_inc;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       res_load;
        logic       found_set;
        logic       stat_load;
        logic [1:0] stat;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       full;
        logic       empty;
        logic       match;
        logic       more1;
        logic       more2;
    } t_sts;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_POP   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

/* rtl/bdq_ctrl.sv */
// Sequencer for the bounded deque: decodes a request and steps the datapath.
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   c;

    always_comb begin
        c           = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    c.take  = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (i_sts.req)
                    REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                        if (i_sts.full) begin
                            c.stat_load = 1'b1;
                            c.stat      = STAT_FULL;
                        end else begin
                            c.wr_en    = 1'b1;
                            c.wr_sel   = (i_sts.req == REQ_PUSH_FRONT) ? WR_HEAD_M : WR_TAIL;
                            c.head_dec = (i_sts.req == REQ_PUSH_FRONT);
                            c.cnt_inc  = 1'b1;
                        end
                    end
                    REQ_POP_FRONT, REQ_POP_BACK: begin
                        if (i_sts.empty) begin
                            c.stat_load = 1'b1;
                            c.stat      = STAT_EMPTY;
                        end else begin
                            c.rd_en  = 1'b1;
                            c.rd_sel = (i_sts.req == REQ_POP_FRONT) ? RD_FRONT : RD_LAST;
                            n_state  = S_POP;
                        end
                    end
                    REQ_REMOVE, REQ_SEARCH: begin
                        if (i_sts.empty) begin
                            c.stat_load = 1'b1;
                            c.stat      = STAT_EMPTY;
                        end else begin
                            c.rd_en  = 1'b1;
                            c.rd_sel = RD_FRONT;
                            c.k_clr  = 1'b1;
                            n_state  = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_POP: begin
                c.res_load = 1'b1;
                c.cnt_dec  = 1'b1;
                c.head_inc = (i_sts.req == REQ_POP_FRONT);
                n_state    = S_DONE;
            end
            S_SCAN: begin
                if (i_sts.match) begin
                    c.found_set = 1'b1;
                    if (i_sts.req == REQ_REMOVE) begin
                        c.res_load = 1'b1;
                        if (i_sts.more1) begin
                            c.rd_en  = 1'b1;
                            c.rd_sel = RD_K1;
                            n_state  = S_SHIFT;
                        end else begin
                            c.cnt_dec = 1'b1;
                            n_state   = S_DONE;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_sts.more1) begin
                    c.k_inc  = 1'b1;
                    c.rd_en  = 1'b1;
                    c.rd_sel = RD_K1;
                end else begin
                    c.stat_load = 1'b1;
                    c.stat      = STAT_NOT_FOUND;
                    n_state     = S_DONE;
                end
            end
            S_SHIFT: begin
                c.wr_en      = 1'b1;
                c.wr_sel     = WR_K;
                c.wr_from_rd = 1'b1;
                c.k_inc      = 1'b1;
                if (i_sts.more2) begin
                    c.rd_en  = 1'b1;
                    c.rd_sel = RD_K2;
                end else begin
                    c.cnt_dec = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    c.out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = c;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/bdq_dpath.sv */
// Entry memory, ring pointers, scan index and result registers of the deque.
module bdq_dpath
    import bdq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [2:0]                  i_req_type,
    input  logic signed [WORD_BITS-1:0] i_value,
    input  t_cmd                        i_cmd,
    output t_sts                        o_sts,
    output logic signed [WORD_BITS-1:0] o_result_value,
    output logic                        o_found,
    output logic [1:0]                  o_status,
    output logic [$clog2(DEPTH+1)-1:0]  o_entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic signed [WORD_BITS-1:0] r_mem [DEPTH];
    logic signed [WORD_BITS-1:0] r_rd_data;
    logic [AW-1:0]               r_head;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_k;
    logic [2:0]                  r_req;
    logic signed [WORD_BITS-1:0] r_word;
    logic signed [WORD_BITS-1:0] r_res;
    logic                        r_found;
    logic [1:0]                  r_stat;
    logic signed [WORD_BITS-1:0] r_out_res;
    logic                        r_out_found;
    logic [1:0]                  r_out_stat;
    logic [CW-1:0]               r_out_count;

    logic [SW-1:0]               k1, k2, last, rd_idx;
    logic [AW-1:0]               head_m, head_p, rd_addr, wr_addr;
    logic signed [WORD_BITS-1:0] wr_data;

    // Physical slot of a logical index counted from the front
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [SW-1:0] idx);
        logic [SW-1:0] s;
        s = SW'(head) + idx;
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign k1     = SW'(r_k) + SW'(1);
    assign k2     = SW'(r_k) + SW'(2);
    assign last   = SW'(r_count) - SW'(1);
    assign head_m = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_p = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_FRONT: rd_idx = '0;
            RD_LAST:  rd_idx = last;
            RD_K1:    rd_idx = k1;
            RD_K2:    rd_idx = k2;
            default:  rd_idx = '0;
        endcase
    end
    assign rd_addr = slot_of(r_head, rd_idx);

    always_comb begin
        case (i_cmd.wr_sel)
            WR_HEAD_M: wr_addr = head_m;
            WR_TAIL:   wr_addr = slot_of(r_head, SW'(r_count));
            WR_K:      wr_addr = slot_of(r_head, SW'(r_k));
            default:   wr_addr = head_m;
        endcase
    end
    assign wr_data = i_cmd.wr_from_rd ? r_rd_data : r_word;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.head_dec) begin
                r_head <= head_m;
            end else if (i_cmd.head_inc) begin
                r_head <= head_p;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req   <= i_req_type;
            r_word  <= i_value;
            r_res   <= '0;
            r_found <= 1'b0;
            r_stat  <= STAT_OK;
        end else begin
            if (i_cmd.res_load) begin
                r_res <= r_rd_data;
            end
            if (i_cmd.found_set) begin
                r_found <= 1'b1;
            end
            if (i_cmd.stat_load) begin
                r_stat <= i_cmd.stat;
            end
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= k1[CW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_res   <= r_res;
            r_out_found <= r_found;
            r_out_stat  <= r_stat;
            r_out_count <= r_count;
        end
    end

    assign o_sts.req   = r_req;
    assign o_sts.full  = (r_count == CW'(DEPTH));
    assign o_sts.empty = (r_count == '0);
    assign o_sts.match = (r_rd_data == r_word);
    assign o_sts.more1 = (k1 < SW'(r_count));
    assign o_sts.more2 = (k2 < SW'(r_count));

    assign o_result_value = r_out_res;
    assign o_found        = r_out_found;
    assign o_status       = r_out_stat;
    assign o_entry_count  = r_out_count;

endmodule

/* rtl/bounded_deque_with_search.sv */
// Top level of the bounded deque of signed words with remove-by-value and search.
//
// A list of up to DEPTH signed words kept in a ring memory with a head pointer
// and a count. Each item on the input channel pushes at the front or back,
// pops from the front or back, removes the first entry equal to i_value
// (later entries move up one place to close the gap) or searches for it.
// Each item yields exactly one result: the popped or removed word, a found
// flag, a status (ok, empty, not found, full) and the count held afterwards.
// A push into a full list is dropped. Items are worked one at a time by a
// sequencer over a single-port-read, single-port-write memory: pushes, empty
// or full rejections and unused codes pass from decode straight to the result
// step, pops read the entry and then load it as the result, a search reads
// entries from the front until one matches or the list ends, and a removal
// scans the same way and then moves each later entry up one place; the
// memory's one read per cycle paces both passes. A new item is taken as soon
// as the sequencer returns to idle, even while the previous result still waits
// in the output register; the sequencer only holds at its final step if that
// register is still full. The memory needs no clearing pass after reset.
module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_req_type,
    input  logic signed [WORD_BITS-1:0] i_value,
    // Result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [WORD_BITS-1:0] o_result_value,
    output logic                        o_found,
    output logic [1:0]                  o_status,
    output logic [$clog2(DEPTH+1)-1:0]  o_entry_count
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer: decode the request, step the scan and gap-closing passes,
    // and hold the finished item until the output register frees up.
    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: ring memory, head and count, scan index, result registers.
    bdq_dpath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_value        (i_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result_value (o_result_value),
        .o_found        (o_found),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

endmodule
